>>> hw/rtl/stream_target_or_terminator_search_assert.svh
// assertion macros shared by the checker of the pattern search block
// needs signals named clock and reset in the including scope
`ifndef STREAM_TARGET_OR_TERMINATOR_SEARCH_ASSERT_SVH
`define STREAM_TARGET_OR_TERMINATOR_SEARCH_ASSERT_SVH

// same-cycle implication, off while reset is high
`define STS_ASSERT_HOLDS(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, off while reset is high
`define STS_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

// checked on the cycle after a reset edge
`define STS_ASSERT_AFTER_RESET(lbl, cons, msg) \
   lbl: assert property (@(posedge clock) reset |=> (cons)) \
      else $error(msg);

`endif

>>> hw/rtl/sts_pkg.sv
// shared types, codes and helper functions of the pattern search block
// used by every module of the block, no dependencies
`timescale 1ns / 1ps

package sts_pkg;

   localparam int MAX_PATTERN_LEN = 8;
   localparam int BSEL_W = $clog2(MAX_PATTERN_LEN);
   localparam int IDX_W = $clog2(MAX_PATTERN_LEN + 1);
   localparam int PAT_W = 8 * MAX_PATTERN_LEN;
   localparam int TICK_W = 16;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DATA_W = 64;
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W = $clog2(QUEUE_DEPTH);

   typedef logic [BSEL_W-1:0] bsel_type;
   typedef logic [IDX_W-1:0] idx_type;
   typedef logic [QPTR_W-1:0] qptr_type;
   typedef logic [QPTR_W:0] qcount_type;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_TARGET_BYTES = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_TARGET_LENGTH = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_TERM_ENABLE = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_TERM_BYTES = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_TERM_LENGTH = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_IDLE_TIMEOUT = 3'd5;

   localparam logic [TICK_W-1:0] IDLE_TIMEOUT_RESET = 16'd1000;
   localparam logic [TICK_W-1:0] TICK_MAX = 16'hFFFF;

   // input modes
   localparam logic [1:0] MODE_START = 2'd0;
   localparam logic [1:0] MODE_BYTE = 2'd1;
   localparam logic [1:0] MODE_TICK = 2'd2;

   // outcome codes
   localparam logic [1:0] OUT_TARGET = 2'd0;
   localparam logic [1:0] OUT_TERM = 2'd1;
   localparam logic [1:0] OUT_TIMEOUT = 2'd2;

   typedef enum logic [1:0] {
      CMD_START,
      CMD_BYTE,
      CMD_TICK
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type kind;
      logic [7:0] data;
   } cmd_type;

   typedef struct packed {
      logic [PAT_W-1:0] target_bytes;
      idx_type target_length;
      logic terminator_enable;
      logic [PAT_W-1:0] terminator_bytes;
      idx_type terminator_length;
      logic [TICK_W-1:0] idle_timeout;
   } cfg_type;

   typedef struct packed {
      logic busy;
      logic hit;
   } match_status_type;

   function automatic logic [7:0] pat_byte(input logic [PAT_W-1:0] bytes, input bsel_type i);
      return bytes[{i, 3'b000} +: 8];
   endfunction

   // lengths above the pattern store clamp to its size
   function automatic idx_type eff_len(input idx_type len);
      return (len > idx_type'(MAX_PATTERN_LEN)) ? idx_type'(MAX_PATTERN_LEN) : len;
   endfunction

endpackage

>>> hw/rtl/sts_match.sv
// one pattern matcher: match index plus a fallback walk, one candidate per cycle
// depends on sts_pkg
`timescale 1ns / 1ps

module sts_match (
   input  logic clock,
   input  logic reset,
   input  logic clear,
   input  logic step,
   input  logic [7:0] c,
   input  logic [sts_pkg::PAT_W-1:0] pat_bytes,
   input  sts_pkg::idx_type pat_len,
   output sts_pkg::match_status_type status
);

   sts_pkg::idx_type idx_ff, idx_in;
   sts_pkg::idx_type orig_ff, orig_in;
   sts_pkg::bsel_type k_ff, k_in;
   logic [7:0] c_ff, c_in;
   logic run_ff, run_in;
   logic hit_ff, hit_in;

   sts_pkg::idx_type idx0;
   sts_pkg::idx_type diff;
   logic prefix_ok;
   logic found;

   always_comb begin
      idx0 = (idx_ff >= pat_len) ? '0 : idx_ff;
      diff = orig_ff - {1'b0, k_ff};

      // candidate prefix of length k must equal the stream tail seen so far
      prefix_ok = 1'b1;
      for (int i = 0; i < sts_pkg::MAX_PATTERN_LEN - 1; i++) begin
         if ((sts_pkg::bsel_type'(i) < k_ff) &&
             (sts_pkg::pat_byte(pat_bytes, sts_pkg::bsel_type'(i)) !=
              sts_pkg::pat_byte(pat_bytes, sts_pkg::bsel_type'(i) + diff[sts_pkg::BSEL_W-1:0])))
            prefix_ok = 1'b0;
      end
      found = (c_ff == sts_pkg::pat_byte(pat_bytes, k_ff)) && prefix_ok;

      idx_in = idx_ff;
      orig_in = orig_ff;
      k_in = k_ff;
      c_in = c_ff;
      run_in = run_ff;
      hit_in = hit_ff;

      priority if (clear) begin
         idx_in = '0;
         run_in = 1'b0;
         hit_in = 1'b0;
      end else if (step) begin
         hit_in = 1'b0;
         c_in = c;
         if (c == sts_pkg::pat_byte(pat_bytes, idx0[sts_pkg::BSEL_W-1:0])) begin
            idx_in = idx0 + sts_pkg::idx_type'(1);
            hit_in = ((idx0 + sts_pkg::idx_type'(1)) == pat_len);
         end else if (idx0 == '0) begin
            idx_in = '0;
         end else begin
            orig_in = idx0;
            k_in = idx0[sts_pkg::BSEL_W-1:0] - sts_pkg::bsel_type'(1);
            run_in = 1'b1;
         end
      end else if (run_ff) begin
         if (found) begin
            idx_in = {1'b0, k_ff} + sts_pkg::idx_type'(1);
            run_in = 1'b0;
         end else if (k_ff == '0) begin
            idx_in = '0;
            run_in = 1'b0;
         end else begin
            k_in = k_ff - sts_pkg::bsel_type'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff <= '0;
         run_ff <= 1'b0;
         hit_ff <= 1'b0;
      end else begin
         idx_ff <= idx_in;
         run_ff <= run_in;
         hit_ff <= hit_in;
      end
      orig_ff <= orig_in;
      k_ff <= k_in;
      c_ff <= c_in;
   end

   assign status.busy = run_ff;
   assign status.hit = hit_ff;

endmodule

>>> hw/rtl/sts_fifo.sv
// short command queue between the front and the back
// depends on sts_pkg
`timescale 1ns / 1ps

module sts_fifo (
   input  logic clock,
   input  logic reset,
   input  logic push,
   input  sts_pkg::cmd_type push_data,
   output logic full,
   input  logic pop,
   output logic not_empty,
   output sts_pkg::cmd_type pop_data
);

   sts_pkg::cmd_type mem_ff [sts_pkg::QUEUE_DEPTH];
   sts_pkg::qptr_type wr_ptr_ff, wr_ptr_in;
   sts_pkg::qptr_type rd_ptr_ff, rd_ptr_in;
   sts_pkg::qcount_type count_ff, count_in;

   logic do_push;
   logic do_pop;

   assign full = (count_ff == sts_pkg::qcount_type'(sts_pkg::QUEUE_DEPTH));
   assign not_empty = (count_ff != '0);
   assign pop_data = mem_ff[rd_ptr_ff];

   always_comb begin
      do_push = push && !full;
      do_pop = pop && not_empty;
      wr_ptr_in = do_push ? wr_ptr_ff + sts_pkg::qptr_type'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + sts_pkg::qptr_type'(1) : rd_ptr_ff;
      count_in = count_ff;
      if (do_push && !do_pop)
         count_in = count_ff + sts_pkg::qcount_type'(1);
      else if (do_pop && !do_push)
         count_in = count_ff - sts_pkg::qcount_type'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
      if (do_push)
         mem_ff[wr_ptr_ff] <= push_data;
   end

endmodule

>>> hw/rtl/sts_front.sv
// front end: takes request words, decodes the mode, drops unused codes
// depends on sts_pkg
`timescale 1ns / 1ps

module sts_front (
   input  logic clock,
   input  logic reset,
   input  logic req_push,
   input  logic [1:0] req_mode,
   input  logic [7:0] req_data_byte,
   output logic req_full,
   output logic cmd_valid,
   output sts_pkg::cmd_type cmd,
   input  logic cmd_ready
);

   logic valid_ff, valid_in;
   sts_pkg::cmd_type cmd_ff, cmd_in;

   logic accept;
   logic keep;
   sts_pkg::cmd_kind_type kind;

   assign req_full = valid_ff && !cmd_ready;
   assign cmd_valid = valid_ff;
   assign cmd = cmd_ff;

   always_comb begin
      accept = req_push && !req_full;
      keep = 1'b1;
      kind = sts_pkg::CMD_START;
      unique case (req_mode)
         sts_pkg::MODE_START: kind = sts_pkg::CMD_START;
         sts_pkg::MODE_BYTE: kind = sts_pkg::CMD_BYTE;
         sts_pkg::MODE_TICK: kind = sts_pkg::CMD_TICK;
         default: keep = 1'b0;
      endcase

      valid_in = valid_ff && !cmd_ready;
      cmd_in = cmd_ff;
      if (accept && keep) begin
         valid_in = 1'b1;
         cmd_in.kind = kind;
         cmd_in.data = req_data_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (reset)
         valid_ff <= 1'b0;
      else
         valid_ff <= valid_in;
      cmd_ff <= cmd_in;
   end

endmodule

>>> hw/rtl/sts_back.sv
// back end: search state, idle tick counter, two matchers and the result register
// depends on sts_pkg and sts_match
`timescale 1ns / 1ps

module sts_back (
   input  logic clock,
   input  logic reset,
   input  sts_pkg::cfg_type cfg,
   input  logic cmd_valid,
   input  sts_pkg::cmd_type cmd,
   output logic cmd_pop,
   output logic rsp_empty,
   input  logic rsp_pop,
   output logic [1:0] rsp_outcome
);

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_WAIT = 1'b1;

   logic state_ff, state_in;
   logic searching_ff, searching_in;
   logic [sts_pkg::TICK_W-1:0] ticks_ff, ticks_in;
   logic out_valid_ff, out_valid_in;
   logic [1:0] out_outcome_ff, out_outcome_in;

   sts_pkg::idx_type t_len;
   sts_pkg::idx_type r_len;
   logic term_on;
   logic [sts_pkg::TICK_W-1:0] tick_sum;
   logic m_clear;
   logic t_step;
   logic r_step;
   sts_pkg::match_status_type t_status;
   sts_pkg::match_status_type r_status;

   sts_match u_target (
      .clock(clock),
      .reset(reset),
      .clear(m_clear),
      .step(t_step),
      .c(cmd.data),
      .pat_bytes(cfg.target_bytes),
      .pat_len(t_len),
      .status(t_status)
   );

   sts_match u_term (
      .clock(clock),
      .reset(reset),
      .clear(m_clear),
      .step(r_step),
      .c(cmd.data),
      .pat_bytes(cfg.terminator_bytes),
      .pat_len(r_len),
      .status(r_status)
   );

   assign rsp_empty = !out_valid_ff;
   assign rsp_outcome = out_outcome_ff;

   always_comb begin
      t_len = sts_pkg::eff_len(cfg.target_length);
      r_len = sts_pkg::eff_len(cfg.terminator_length);
      term_on = cfg.terminator_enable;
      tick_sum = (ticks_ff == sts_pkg::TICK_MAX) ? ticks_ff
                                                 : ticks_ff + sts_pkg::TICK_W'(1);

      state_in = state_ff;
      searching_in = searching_ff;
      ticks_in = ticks_ff;
      out_valid_in = out_valid_ff && !rsp_pop;
      out_outcome_in = out_outcome_ff;
      m_clear = 1'b0;
      t_step = 1'b0;
      r_step = 1'b0;
      cmd_pop = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            // one result slot: only take a word once the slot is free
            if (cmd_valid && !out_valid_ff) begin
               cmd_pop = 1'b1;
               case (cmd.kind)
                  sts_pkg::CMD_START: begin
                     m_clear = 1'b1;
                     ticks_in = '0;
                     searching_in = 1'b1;
                     if (t_len == '0) begin
                        searching_in = 1'b0;
                        out_valid_in = 1'b1;
                        out_outcome_in = sts_pkg::OUT_TARGET;
                     end else if (term_on && (r_len == '0)) begin
                        searching_in = 1'b0;
                        out_valid_in = 1'b1;
                        out_outcome_in = sts_pkg::OUT_TERM;
                     end
                  end
                  sts_pkg::CMD_BYTE: begin
                     if (searching_ff) begin
                        ticks_in = '0;
                        t_step = 1'b1;
                        r_step = term_on;
                        state_in = ST_WAIT;
                     end
                  end
                  sts_pkg::CMD_TICK: begin
                     if (searching_ff) begin
                        ticks_in = tick_sum;
                        if (tick_sum >= cfg.idle_timeout) begin
                           searching_in = 1'b0;
                           out_valid_in = 1'b1;
                           out_outcome_in = sts_pkg::OUT_TIMEOUT;
                        end
                     end
                  end
                  default: ;
               endcase
            end
         end
         ST_WAIT: begin
            // target wins over terminator when both complete on one byte
            if (!t_status.busy && !r_status.busy) begin
               state_in = ST_IDLE;
               if (t_status.hit) begin
                  searching_in = 1'b0;
                  out_valid_in = 1'b1;
                  out_outcome_in = sts_pkg::OUT_TARGET;
               end else if (term_on && r_status.hit) begin
                  searching_in = 1'b0;
                  out_valid_in = 1'b1;
                  out_outcome_in = sts_pkg::OUT_TERM;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         searching_ff <= 1'b0;
         ticks_ff <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         searching_ff <= searching_in;
         ticks_ff <= ticks_in;
         out_valid_ff <= out_valid_in;
      end
      out_outcome_ff <= out_outcome_in;
   end

endmodule

>>> hw/rtl/stream_target_or_terminator_search.sv
// top level of the stream pattern search: register file, front, queue and back
// depends on sts_pkg, sts_front, sts_fifo and sts_back
`timescale 1ns / 1ps

// usage
// - req channel: push a word (mode, data_byte) while full is low. mode start
//   begins a search, byte feeds one stream byte, tick counts one idle tick;
//   mode 3 is dropped at the front
// - rsp channel: while empty is low, rsp_outcome holds the oldest result
//   (target, terminator or timeout); pop takes it
// - csr channel: csr_ready is always high, one register written per word,
//   indexes above the list are ignored; write only while no word is in flight
// - throughput: the back takes one start or tick per cycle while the result
//   slot is free; a byte holds it in the wait state until the fallback walk,
//   which tries one candidate prefix length a cycle in each matcher, ends
// - a 4-word queue lets the front keep taking words while the back works
// - a stalled rsp side holds the result; the back then stops taking words
//   and full rises once the queue and front stage fill
// - reset clears the search, queue and result, and loads register defaults
//   (idle_timeout 1000, all else zero)
module stream_target_or_terminator_search (
   input  logic clock,
   input  logic reset,
   input  logic req_push,
   output logic req_full,
   input  logic [1:0] req_mode,
   input  logic [7:0] req_data_byte,
   output logic rsp_empty,
   input  logic rsp_pop,
   output logic [1:0] rsp_outcome,
   input  logic csr_valid,
   output logic csr_ready,
   input  logic [sts_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [sts_pkg::CSR_DATA_W-1:0] csr_wdata
);

   sts_pkg::cfg_type cfg_ff, cfg_in;

   logic front_valid;
   sts_pkg::cmd_type front_cmd;
   logic q_full;
   logic q_not_empty;
   sts_pkg::cmd_type q_cmd;
   logic q_pop;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (reset) begin
         cfg_in = '0;
         cfg_in.idle_timeout = sts_pkg::IDLE_TIMEOUT_RESET;
      end else if (csr_valid) begin
         unique case (csr_index)
            sts_pkg::CSR_TARGET_BYTES: cfg_in.target_bytes = csr_wdata;
            sts_pkg::CSR_TARGET_LENGTH:
               cfg_in.target_length = csr_wdata[sts_pkg::IDX_W-1:0];
            sts_pkg::CSR_TERM_ENABLE: cfg_in.terminator_enable = csr_wdata[0];
            sts_pkg::CSR_TERM_BYTES: cfg_in.terminator_bytes = csr_wdata;
            sts_pkg::CSR_TERM_LENGTH:
               cfg_in.terminator_length = csr_wdata[sts_pkg::IDX_W-1:0];
            sts_pkg::CSR_IDLE_TIMEOUT:
               cfg_in.idle_timeout = csr_wdata[sts_pkg::TICK_W-1:0];
            default: ;
         endcase
      end
   end

   // reset value is loaded through cfg_in
   always_ff @(posedge clock) begin
      cfg_ff <= cfg_in;
   end

   sts_front u_front (
      .clock(clock),
      .reset(reset),
      .req_push(req_push),
      .req_mode(req_mode),
      .req_data_byte(req_data_byte),
      .req_full(req_full),
      .cmd_valid(front_valid),
      .cmd(front_cmd),
      .cmd_ready(!q_full)
   );

   sts_fifo u_fifo (
      .clock(clock),
      .reset(reset),
      .push(front_valid),
      .push_data(front_cmd),
      .full(q_full),
      .pop(q_pop),
      .not_empty(q_not_empty),
      .pop_data(q_cmd)
   );

   sts_back u_back (
      .clock(clock),
      .reset(reset),
      .cfg(cfg_ff),
      .cmd_valid(q_not_empty),
      .cmd(q_cmd),
      .cmd_pop(q_pop),
      .rsp_empty(rsp_empty),
      .rsp_pop(rsp_pop),
      .rsp_outcome(rsp_outcome)
   );

endmodule

>>> hw/rtl/sts_checker.sv
// port-level checks on the pattern search block, bound to the top level
// depends on sts_pkg and the assertion macro header
`timescale 1ns / 1ps
`include "stream_target_or_terminator_search_assert.svh"

module sts_checker (
   input logic clock,
   input logic reset,
   input logic req_full,
   input logic rsp_empty,
   input logic rsp_pop,
   input logic [1:0] rsp_outcome
);

   // a waiting result stays put until popped
   `STS_ASSERT_NEXT(a_rsp_hold, !rsp_empty && !rsp_pop, !rsp_empty && $stable(rsp_outcome), "result changed while stalled")

   // only the three outcome codes ever show
   `STS_ASSERT_HOLDS(a_outcome_code, !rsp_empty, rsp_outcome == sts_pkg::OUT_TARGET || rsp_outcome == sts_pkg::OUT_TERM || rsp_outcome == sts_pkg::OUT_TIMEOUT, "illegal outcome code")

   // reset leaves no result and an open request side
   `STS_ASSERT_AFTER_RESET(a_reset_clean, rsp_empty && !req_full, "state not cleared by reset")

endmodule

bind stream_target_or_terminator_search sts_checker u_sts_checker (
   .clock(clock),
   .reset(reset),
   .req_full(req_full),
   .rsp_empty(rsp_empty),
   .rsp_pop(rsp_pop),
   .rsp_outcome(rsp_outcome)
);

>>> sim/stream_target_or_terminator_search_tb.sv
`timescale 1ns / 1ps

// testbench of the stream pattern search block: a directed stimulus table, then
// random search phases, most words checked against a predictor kept in this file
// depends on sts_pkg and stream_target_or_terminator_search
module stream_target_or_terminator_search_tb;
   import sts_pkg::*;

   localparam logic [1:0] MODE_UNUSED = 2'd3;
   localparam int DRAIN_CYCLES = 80;
   localparam int HOLD_CYCLES = 400;
   localparam int RANDOM_WORDS = 1000;

   typedef enum logic [0:0] {
      ROW_WRITE,
      ROW_WORD
   } row_kind_type;

   typedef enum logic [1:0] {
      CHK_MODEL,
      CHK_NONE,
      CHK_CODE
   } row_check_type;

   typedef struct packed {
      row_kind_type kind;
      logic [CSR_IDX_W-1:0] index;
      logic [1:0] mode;
      logic [CSR_DATA_W-1:0] value;
      row_check_type check;
      logic [1:0] outcome;
   } plan_row_type;

   typedef struct {
      bit hit;
      int idx;
   } match_step_type;

   logic clock;
   logic reset;
   logic req_push;
   logic req_full;
   logic [1:0] req_mode;
   logic [7:0] req_data_byte;
   logic rsp_empty;
   logic rsp_pop;
   logic [1:0] rsp_outcome;
   logic csr_valid;
   logic csr_ready;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   stream_target_or_terminator_search dut (
      .clock(clock),
      .reset(reset),
      .req_push(req_push),
      .req_full(req_full),
      .req_mode(req_mode),
      .req_data_byte(req_data_byte),
      .rsp_empty(rsp_empty),
      .rsp_pop(rsp_pop),
      .rsp_outcome(rsp_outcome),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   // predictor copy of registers and search state
   cfg_type shadow_cfg;
   int target_pos;
   int term_pos;
   logic [TICK_W-1:0] idle_count;
   bit search_on;

   logic [1:0] pending_outcomes[$];
   int error_count;
   int counted_words;
   int burst_left;
   bit sender_eager;
   bit words_since_drain;
   bit hold_req;

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("FAIL");
      $finish;
   end

   task automatic flag_mismatch(input string what);
      $display("mismatch at %0t ns: %s", $time, what);
      error_count++;
   endtask

   function automatic logic [7:0] byte_at(input logic [PAT_W-1:0] pat, input int i);
      return pat[8 * (i % 8) +: 8];
   endfunction

   function automatic int clamp_len(input idx_type len);
      return (int'(len) > MAX_PATTERN_LEN) ? MAX_PATTERN_LEN : int'(len);
   endfunction

   // one byte through one matcher, with the prefix fallback on a miss
   function automatic match_step_type step_matcher(input logic [PAT_W-1:0] pat, input int len,
                                                   input int pos, input logic [7:0] c);
      match_step_type r;
      int cur;
      int diff;
      bit fits;
      cur = (pos >= len) ? 0 : pos;
      r.hit = 1'b0;
      r.idx = 0;
      if (c == byte_at(pat, cur)) begin
         r.idx = cur + 1;
         r.hit = (cur + 1 == len);
         return r;
      end
      if (cur == 0) return r;
      for (int k = cur - 1; k >= 0; k--) begin
         if (c == byte_at(pat, k)) begin
            if (k == 0) begin
               r.idx = 1;
               return r;
            end
            diff = cur - k;
            fits = 1'b1;
            for (int i = 0; i < k; i++)
               if (byte_at(pat, i) != byte_at(pat, i + diff)) fits = 1'b0;
            if (fits) begin
               r.idx = k + 1;
               return r;
            end
         end
      end
      return r;
   endfunction

   task automatic predict_search(input logic [1:0] m, input logic [7:0] d,
                                 output bit produced, output logic [1:0] code);
      int tlen;
      int rlen;
      match_step_type s;
      produced = 1'b0;
      code = OUT_TARGET;
      tlen = clamp_len(shadow_cfg.target_length);
      rlen = clamp_len(shadow_cfg.terminator_length);
      case (m)
         MODE_START: begin
            target_pos = 0;
            term_pos = 0;
            idle_count = '0;
            search_on = 1'b1;
            if (tlen == 0) begin
               search_on = 1'b0;
               produced = 1'b1;
               code = OUT_TARGET;
            end else if (shadow_cfg.terminator_enable && rlen == 0) begin
               search_on = 1'b0;
               produced = 1'b1;
               code = OUT_TERM;
            end
         end
         MODE_BYTE: begin
            if (search_on) begin
               idle_count = '0;
               s = step_matcher(shadow_cfg.target_bytes, tlen, target_pos, d);
               target_pos = s.idx;
               if (s.hit) begin
                  search_on = 1'b0;
                  produced = 1'b1;
                  code = OUT_TARGET;
               end else if (shadow_cfg.terminator_enable) begin
                  s = step_matcher(shadow_cfg.terminator_bytes, rlen, term_pos, d);
                  term_pos = s.idx;
                  if (s.hit) begin
                     search_on = 1'b0;
                     produced = 1'b1;
                     code = OUT_TERM;
                  end
               end
            end
         end
         MODE_TICK: begin
            if (search_on) begin
               if (idle_count != TICK_MAX) idle_count = idle_count + 1'b1;
               if (idle_count >= shadow_cfg.idle_timeout) begin
                  search_on = 1'b0;
                  produced = 1'b1;
                  code = OUT_TIMEOUT;
               end
            end
         end
         default: ;
      endcase
   endtask

   // let the block run dry: all outcomes in, then an idle drain wait
   task automatic wait_drained();
      @(negedge clock);
      req_push = 1'b0;
      while (pending_outcomes.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      words_since_drain = 1'b0;
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] val);
      if (words_since_drain) wait_drained();
      @(negedge clock);
      req_push = 1'b0;
      csr_valid = 1'b1;
      csr_index = idx;
      csr_wdata = val;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         CSR_TARGET_BYTES: shadow_cfg.target_bytes = val;
         CSR_TARGET_LENGTH: shadow_cfg.target_length = val[3:0];
         CSR_TERM_ENABLE: shadow_cfg.terminator_enable = val[0];
         CSR_TERM_BYTES: shadow_cfg.terminator_bytes = val;
         CSR_TERM_LENGTH: shadow_cfg.terminator_length = val[3:0];
         CSR_IDLE_TIMEOUT: shadow_cfg.idle_timeout = val[TICK_W-1:0];
         default: ;
      endcase
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   task automatic send_word(input logic [1:0] m, input logic [7:0] d,
                            input row_check_type chk, input logic [1:0] typed);
      int gap;
      bit produced;
      bit counts;
      logic [1:0] code;
      @(negedge clock);
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         if ($urandom_range(0, 15) == 0) gap = $urandom_range(9, 30);
         if (sender_eager) gap = 0;
         if (gap > 0) begin
            req_push = 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
      burst_left--;
      req_push = 1'b1;
      req_mode = m;
      req_data_byte = d;
      do @(posedge clock); while (req_full);
      counts = (m == MODE_START) || (search_on && (m == MODE_BYTE || m == MODE_TICK));
      predict_search(m, d, produced, code);
      case (chk)
         CHK_MODEL: if (produced) pending_outcomes.push_back(code);
         CHK_CODE: pending_outcomes.push_back(typed);
         default: ;
      endcase
      words_since_drain = 1'b1;
      if (counts) counted_words++;
   endtask

   function automatic logic [CSR_DATA_W-1:0] upper_noise();
      return ($urandom_range(0, 1) == 0) ? '0 : {$urandom, $urandom};
   endfunction

   function automatic logic [3:0] pick_len();
      int r;
      r = $urandom_range(0, 19);
      if (r == 0) return 4'd0;
      if (r == 1) return 4'd8;
      if (r == 2) return 4'($urandom_range(9, 15));
      return 4'($urandom_range(1, 8));
   endfunction

   // mostly two-letter patterns so that prefixes repeat and the fallback walks
   function automatic logic [PAT_W-1:0] build_pattern();
      logic [PAT_W-1:0] p;
      logic [7:0] a;
      logic [7:0] b;
      p = {$urandom, $urandom};
      a = 8'($urandom_range(0, 255));
      b = 8'($urandom_range(0, 255));
      if ($urandom_range(0, 3) != 0)
         for (int i = 0; i < MAX_PATTERN_LEN; i++) p[8 * i +: 8] = $urandom_range(0, 1) ? a : b;
      return p;
   endfunction

   task automatic configure_patterns(input bit all);
      logic [CSR_DATA_W-1:0] v;
      int r;
      if (all || $urandom_range(0, 4) < 3) write_reg(CSR_TARGET_BYTES, build_pattern());
      if (all || $urandom_range(0, 4) < 3) begin
         v = upper_noise();
         v[3:0] = pick_len();
         write_reg(CSR_TARGET_LENGTH, v);
      end
      if (all || $urandom_range(0, 4) < 2) begin
         v = upper_noise();
         v[0] = ($urandom_range(0, 3) != 0);
         write_reg(CSR_TERM_ENABLE, v);
      end
      if (all || $urandom_range(0, 4) < 3) write_reg(CSR_TERM_BYTES, build_pattern());
      if (all || $urandom_range(0, 4) < 3) begin
         v = upper_noise();
         v[3:0] = pick_len();
         write_reg(CSR_TERM_LENGTH, v);
      end
      if (all || $urandom_range(0, 4) < 3) begin
         v = upper_noise();
         r = $urandom_range(0, 9);
         case (r)
            0: v[TICK_W-1:0] = '0;
            1: v[TICK_W-1:0] = TICK_MAX;
            2: v[TICK_W-1:0] = 16'd1;
            default: v[TICK_W-1:0] = 16'($urandom_range(2, 40));
         endcase
         write_reg(CSR_IDLE_TIMEOUT, v);
      end
      if ($urandom_range(0, 7) == 0) write_reg(CSR_IDX_W'($urandom_range(6, 7)), {$urandom, $urandom});
   endtask

   task automatic run_phase(input int phase);
      int goal;
      int sel;
      int plen;
      int pre;
      bit paused;
      logic [PAT_W-1:0] pat;
      configure_patterns(phase == 0);
      sender_eager = ($urandom_range(0, 3) == 0);
      paused = 1'b0;
      // receiver backs off for a long stretch while words keep coming
      if (phase == 2) hold_req = 1'b1;
      goal = counted_words + $urandom_range(40, 90);
      if ($urandom_range(0, 3) != 0) send_word(MODE_START, 8'($urandom), CHK_MODEL, OUT_TARGET);
      while (counted_words < goal) begin
         if (phase == 4 && !paused && counted_words + 25 > goal) begin
            paused = 1'b1;
            @(negedge clock);
            req_push = 1'b0;
            while (pending_outcomes.size() != 0) @(posedge clock);
         end
         sel = $urandom_range(0, 99);
         if ((!search_on && sel < 70) || sel < 6) begin
            send_word(MODE_START, 8'($urandom), CHK_MODEL, OUT_TARGET);
         end else if (sel < 16) begin
            send_word(MODE_TICK, 8'($urandom), CHK_MODEL, OUT_TARGET);
         end else if (sel < 19) begin
            send_word(MODE_UNUSED, 8'($urandom), CHK_MODEL, OUT_TARGET);
         end else if (sel < 29) begin
            // a partial copy, then a whole copy of one pattern
            if (shadow_cfg.terminator_enable && $urandom_range(0, 1)) begin
               pat = shadow_cfg.terminator_bytes;
               plen = clamp_len(shadow_cfg.terminator_length);
            end else begin
               pat = shadow_cfg.target_bytes;
               plen = clamp_len(shadow_cfg.target_length);
            end
            pre = $urandom_range(0, plen);
            for (int i = 0; i < pre; i++) send_word(MODE_BYTE, byte_at(pat, i), CHK_MODEL, OUT_TARGET);
            for (int i = 0; i < plen; i++) send_word(MODE_BYTE, byte_at(pat, i), CHK_MODEL, OUT_TARGET);
         end else if ($urandom_range(0, 9) < 7) begin
            pat = $urandom_range(0, 1) ? shadow_cfg.target_bytes : shadow_cfg.terminator_bytes;
            send_word(MODE_BYTE, byte_at(pat, $urandom_range(0, 7)), CHK_MODEL, OUT_TARGET);
         end else begin
            send_word(MODE_BYTE, 8'($urandom), CHK_MODEL, OUT_TARGET);
         end
      end
   endtask

   function automatic plan_row_type write_row(input logic [CSR_IDX_W-1:0] idx,
                                              input logic [CSR_DATA_W-1:0] val);
      plan_row_type r;
      r = '0;
      r.kind = ROW_WRITE;
      r.index = idx;
      r.value = val;
      return r;
   endfunction

   function automatic plan_row_type word_row(input logic [1:0] m, input logic [7:0] d,
                                             input row_check_type chk, input logic [1:0] code);
      plan_row_type r;
      r = '0;
      r.kind = ROW_WORD;
      r.mode = m;
      r.value = {56'd0, d};
      r.check = chk;
      r.outcome = code;
      return r;
   endfunction

   // result side: the stall pattern steps through four modes in turn
   initial begin : receiver
      int rx_cycle;
      bit take;
      logic [1:0] want;
      rsp_pop = 1'b0;
      rx_cycle = 0;
      forever begin
         @(negedge clock);
         if (hold_req) begin
            hold_req = 1'b0;
            rsp_pop = 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
         end
         rx_cycle++;
         case ((rx_cycle / 128) % 4)
            0: take = 1'b1;
            1: take = $urandom_range(0, 1);
            2: take = (rx_cycle % 5 == 0);
            default: take = ($urandom_range(0, 7) != 0);
         endcase
         rsp_pop = take;
         @(posedge clock);
         if (rsp_pop && !rsp_empty) begin
            if (pending_outcomes.size() == 0) begin
               flag_mismatch($sformatf("outcome %0d with nothing expected", rsp_outcome));
            end else begin
               want = pending_outcomes.pop_front();
               if (rsp_outcome !== want)
                  flag_mismatch($sformatf("outcome %0d, expected %0d", rsp_outcome, want));
            end
         end
      end
   end

   initial begin : stimulus
      plan_row_type plan[$];
      int phase;
      int random_floor;
      reset = 1'b1;
      req_push = 1'b0;
      req_mode = MODE_START;
      req_data_byte = '0;
      csr_valid = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      shadow_cfg = '0;
      shadow_cfg.idle_timeout = IDLE_TIMEOUT_RESET;
      target_pos = 0;
      term_pos = 0;
      idle_count = '0;
      search_on = 1'b0;
      error_count = 0;
      counted_words = 0;
      burst_left = 0;
      sender_eager = 1'b0;
      words_since_drain = 1'b0;
      hold_req = 1'b0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // no search yet: words are dropped
      plan.push_back(word_row(MODE_BYTE, 8'hFF, CHK_NONE, OUT_TARGET));
      plan.push_back(word_row(MODE_TICK, 8'h00, CHK_NONE, OUT_TARGET));
      plan.push_back(word_row(MODE_UNUSED, 8'hFF, CHK_NONE, OUT_TARGET));
      // empty target hits at once
      plan.push_back(word_row(MODE_START, 8'h00, CHK_CODE, OUT_TARGET));
      plan.push_back(write_row(CSR_TERM_ENABLE, 64'd1));
      plan.push_back(write_row(CSR_TARGET_LENGTH, 64'hF));
      plan.push_back(write_row(CSR_TARGET_BYTES, '1));
      // oversized target clamps, empty terminator hits at once
      plan.push_back(word_row(MODE_START, 8'hFF, CHK_CODE, OUT_TERM));
      plan.push_back(write_row(CSR_TERM_LENGTH, 64'd2));
      plan.push_back(write_row(CSR_TERM_BYTES, '0));
      plan.push_back(write_row(CSR_IDLE_TIMEOUT, '0));
      // zero timeout: first tick ends the search
      plan.push_back(word_row(MODE_START, 8'h00, CHK_MODEL, OUT_TARGET));
      plan.push_back(word_row(MODE_TICK, 8'hFF, CHK_CODE, OUT_TIMEOUT));
      plan.push_back(write_row(CSR_IDLE_TIMEOUT, 64'd2));
      plan.push_back(word_row(MODE_START, 8'h00, CHK_MODEL, OUT_TARGET));
      plan.push_back(word_row(MODE_BYTE, 8'hFF, CHK_MODEL, OUT_TARGET));
      plan.push_back(word_row(MODE_BYTE, 8'h00, CHK_MODEL, OUT_TARGET));
      plan.push_back(word_row(MODE_TICK, 8'h00, CHK_MODEL, OUT_TARGET));
      plan.push_back(word_row(MODE_BYTE, 8'h00, CHK_MODEL, OUT_TARGET));
      plan.push_back(word_row(MODE_START, 8'h00, CHK_MODEL, OUT_TARGET));
      plan.push_back(word_row(MODE_TICK, 8'h00, CHK_MODEL, OUT_TARGET));
      plan.push_back(word_row(MODE_TICK, 8'h00, CHK_CODE, OUT_TIMEOUT));
      plan.push_back(write_row(CSR_IDX_W'(7), '1));
      // search left running into the first random phase
      plan.push_back(word_row(MODE_START, 8'hFF, CHK_MODEL, OUT_TARGET));
      plan.push_back(word_row(MODE_UNUSED, 8'h00, CHK_MODEL, OUT_TARGET));

      foreach (plan[i]) begin
         if (plan[i].kind == ROW_WRITE)
            write_reg(plan[i].index, plan[i].value);
         else
            send_word(plan[i].mode, plan[i].value[7:0], plan[i].check, plan[i].outcome);
      end

      phase = 0;
      random_floor = counted_words;
      while (counted_words - random_floor < RANDOM_WORDS) begin
         run_phase(phase);
         phase++;
      end

      wait_drained();
      if (error_count == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule

>>> filelist.f
+incdir+hw/rtl
hw/rtl/sts_pkg.sv
hw/rtl/sts_match.sv
hw/rtl/sts_fifo.sv
hw/rtl/sts_front.sv
hw/rtl/sts_back.sv
hw/rtl/stream_target_or_terminator_search.sv
hw/rtl/sts_checker.sv
sim/stream_target_or_terminator_search_tb.sv
